/* hdl/gdr_pkg.sv */
// ----------------------------------------------------------------------------
// gdr_pkg
// Command and status bundles shared by the reachability controller and
// datapath.
// ----------------------------------------------------------------------------
package gdr_pkg;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic capture;
        logic adj_rd_from;
        logic adj_rd_node;
        logic adj_write;
        logic start;
        logic pop;
        logic load_fresh;
        logic push;
        logic out_load;
        logic out_value;
    } gdr_cmd_t;

    typedef struct packed {
        logic ok;
        logic stack_empty;
        logic top_is_dst;
        logic fresh_empty;
        logic out_free;
    } gdr_sts_t;

endpackage

/* hdl/gdr_ctrl.sv */
// ----------------------------------------------------------------------------
// gdr_ctrl
// Sequencer for edge insertion and depth-first reachability search.
// ----------------------------------------------------------------------------
module gdr_ctrl
    import gdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     action,
    output logic     in_stall,
    input  gdr_sts_t sts,
    output gdr_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_START,
        ST_POP,
        ST_NODE,
        ST_FETCH,
        ST_PUSH,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   found_reg, found_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (action == ACT_QUERY) ? ST_Q_START : ST_ADD_RD;
                end
            end
            ST_ADD_RD:
            begin
                if (sts.ok)
                begin
                    cmd.adj_rd_from = 1'b1;
                    state_next      = ST_ADD_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_WR:
            begin
                cmd.adj_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_Q_START:
            begin
                if (sts.ok)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_POP;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_POP:
            begin
                if (sts.stack_empty)
                begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_NODE;
                end
            end
            ST_NODE:
            begin
                if (sts.top_is_dst)
                begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.adj_rd_node = 1'b1;
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.load_fresh = 1'b1;
                state_next     = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.fresh_empty)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_value = found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

endmodule

/* hdl/gdr_datapath.sv */
// ----------------------------------------------------------------------------
// gdr_datapath
// Adjacency memory, search stack, visited set and result register.
// ----------------------------------------------------------------------------
module gdr_datapath
    import gdr_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] from_node,
    input  logic [3:0] to_node,
    input  gdr_cmd_t   cmd,
    output gdr_sts_t   sts,
    input  logic       out_stall,
    output logic       out_valid,
    output logic       path_found
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DW = $clog2(NODES + 1);
    localparam logic [NODES-1:0] ONE = NODES'(1);

    logic [NODES-1:0] adj_mem [NODES];
    logic [NODES-1:0] adj_vld_reg;
    logic [NODES-1:0] adj_q;
    logic             adj_vld_q;
    logic [IW-1:0]    stack_mem [NODES];
    logic [IW-1:0]    stack_q;
    logic [DW-1:0]    depth_reg;
    logic [DW-1:0]    depth_m1;
    logic [NODES-1:0] visited_reg;
    logic [NODES-1:0] fresh_reg;
    logic [IW-1:0]    from_reg;
    logic [IW-1:0]    to_reg;
    logic             ok_reg;
    logic             out_valid_reg;
    logic             path_found_reg;
    logic [NODES-1:0] adj_row;
    logic [NODES-1:0] fresh_low;
    logic [IW-1:0]    fresh_idx;
    logic [IW-1:0]    adj_addr;

    function automatic logic [IW-1:0] low_index(input logic [NODES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (v[i])
            begin
                idx = idx | IW'(i);
            end
        end
        return idx;
    endfunction

    assign depth_m1  = depth_reg - DW'(1);
    assign adj_row   = adj_vld_q ? adj_q : '0;
    assign fresh_low = fresh_reg & (~fresh_reg + ONE);
    assign fresh_idx = low_index(fresh_low);
    assign adj_addr  = cmd.adj_rd_node ? stack_q : from_reg;

    assign sts.ok          = ok_reg;
    assign sts.stack_empty = (depth_reg == '0);
    assign sts.top_is_dst  = (stack_q == to_reg);
    assign sts.fresh_empty = (fresh_reg == '0);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign path_found = path_found_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            from_reg <= IW'(from_node);
            to_reg   <= IW'(to_node);
            ok_reg   <= (32'(from_node) < 32'(NODES)) && (32'(to_node) < 32'(NODES));
        end
        if (cmd.adj_rd_from || cmd.adj_rd_node)
        begin
            adj_q     <= adj_mem[adj_addr];
            adj_vld_q <= adj_vld_reg[adj_addr];
        end
        if (cmd.adj_write)
        begin
            adj_mem[from_reg] <= adj_row | (ONE << to_reg);
        end
        if (cmd.start)
        begin
            stack_mem[0] <= from_reg;
        end
        else if (cmd.push)
        begin
            stack_mem[depth_reg[IW-1:0]] <= fresh_idx;
        end
        if (cmd.pop)
        begin
            stack_q <= stack_mem[depth_m1[IW-1:0]];
        end
        if (cmd.start)
        begin
            visited_reg <= ONE << from_reg;
        end
        else if (cmd.load_fresh)
        begin
            visited_reg <= visited_reg | (adj_row & ~visited_reg);
        end
        if (cmd.load_fresh)
        begin
            fresh_reg <= adj_row & ~visited_reg;
        end
        else if (cmd.push)
        begin
            fresh_reg <= fresh_reg & ~fresh_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_vld_reg    <= '0;
            depth_reg      <= '0;
            out_valid_reg  <= 1'b0;
            path_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.adj_write)
            begin
                adj_vld_reg[from_reg] <= 1'b1;
            end
            if (cmd.start)
            begin
                depth_reg <= DW'(1);
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_m1;
            end
            else if (cmd.push)
            begin
                depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg  <= 1'b1;
                path_found_reg <= cmd.out_value;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/graph_dfs_reachability.sv */
// ----------------------------------------------------------------------------
// graph_dfs_reachability
// Directed-graph reachability: add-edge requests fill an adjacency memory,
// query requests run a depth-first search and return one path_found result.
// ----------------------------------------------------------------------------
// Add-edge request: a row read, then a row write; no result is returned.
// Query: setup, then per node a pop and a destination check; a node that is not
// the destination has its row read and its unvisited neighbours loaded and pushed
// one by one. A miss ends at an empty stack; the result is loaded on return to idle.
// One request in flight; the result register lets the next request enter
// while a result waits. Reset empties the graph at once (row valid bits).
// ----------------------------------------------------------------------------
module graph_dfs_reachability
    import gdr_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [3:0] from_node,
    input  logic [3:0] to_node,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       path_found
);

    gdr_cmd_t cmd;
    gdr_sts_t sts;

    gdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdr_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .from_node  (from_node),
        .to_node    (to_node),
        .cmd        (cmd),
        .sts        (sts),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .path_found (path_found)
    );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for graph_dfs_reachability. Add-edge requests update a local copy of
// the adjacency map. Each query request queues the reachability answer that a
// depth-first search over that copy gives. Results are checked in order.
// Both sides idle at random in two phases, then run without idling in a third.
// ----------------------------------------------------------------------------
module tb
    import gdr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   RANDOM_REQUESTS = 1630;

    class reach_scoreboard;
        logic [15:0] adj_rows [16];
        bit          found_q [$];
        int unsigned failures;

        function new();
            foreach (adj_rows[i])
            begin
                adj_rows[i] = '0;
            end
            failures = 0;
        endfunction

        function bit reachable(bit [3:0] src, bit [3:0] dst);
            logic [15:0] seen;
            logic [15:0] fresh;
            bit   [3:0]  pending [16];
            bit   [3:0]  node;
            int          depth;
            seen       = 16'b1 << src;
            pending[0] = src;
            depth      = 1;
            while (depth > 0)
            begin
                depth--;
                node = pending[depth];
                if (node == dst)
                begin
                    return 1'b1;
                end
                fresh = adj_rows[node] & ~seen;
                for (int b = 0; b < 16; b++)
                begin
                    if (fresh[b])
                    begin
                        seen[b]        = 1'b1;
                        pending[depth] = 4'(b);
                        depth++;
                    end
                end
            end
            return 1'b0;
        endfunction

        task report(string what);
            failures++;
            $display("%0t ns  mismatch: %s", $time, what);
        endtask

        function void note_request(logic act, bit [3:0] src, bit [3:0] dst);
            if (act == ACT_ADD)
            begin
                adj_rows[src][dst] = 1'b1;
            end
            else
            begin
                found_q.push_back(reachable(src, dst));
            end
        endfunction

        task check_result(logic found);
            bit want;
            if (found_q.size() == 0)
            begin
                report($sformatf("path_found=%b with no query pending", found));
                return;
            end
            want = found_q.pop_front();
            if (found !== want)
            begin
                report($sformatf("path_found=%b, predicted %b", found, want));
            end
        endtask

        function int outstanding();
            return found_q.size();
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic       action     = ACT_ADD;
    logic [3:0] from_node  = '0;
    logic [3:0] to_node    = '0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       path_found;

    int sender_idle_pct    = 27;
    int receiver_stall_pct = 54;

    reach_scoreboard sb = new();

    graph_dfs_reachability dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .from_node  (from_node),
        .to_node    (to_node),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .path_found (path_found)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(path_found);
        end
    end

    // enter at a falling edge, leave at the falling edge after acceptance
    task send_request(logic act, bit [3:0] src, bit [3:0] dst);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        from_node <= src;
        to_node   <= dst;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_request(act, src, dst);
        @(negedge clk);
    endtask

    initial
    begin
        int a;
        int b;
        int tmp;
        bit is_add;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(ACT_QUERY, 4'd0,  4'd0);
        send_request(ACT_QUERY, 4'd15, 4'd15);
        send_request(ACT_QUERY, 4'd0,  4'd15);
        send_request(ACT_QUERY, 4'd15, 4'd0);
        send_request(ACT_ADD,   4'd0,  4'd1);
        send_request(ACT_ADD,   4'd1,  4'd2);
        send_request(ACT_QUERY, 4'd0,  4'd2);
        send_request(ACT_QUERY, 4'd2,  4'd0);
        send_request(ACT_ADD,   4'd2,  4'd0);
        send_request(ACT_ADD,   4'd0,  4'd1);
        send_request(ACT_QUERY, 4'd2,  4'd1);
        send_request(ACT_ADD,   4'd15, 4'd15);
        send_request(ACT_QUERY, 4'd15, 4'd15);
        send_request(ACT_QUERY, 4'd15, 4'd14);
        send_request(ACT_ADD,   4'd15, 4'd9);
        send_request(ACT_ADD,   4'd9,  4'd9);
        send_request(ACT_ADD,   4'd9,  4'd0);
        send_request(ACT_QUERY, 4'd15, 4'd2);
        send_request(ACT_QUERY, 4'd9,  4'd15);
        send_request(ACT_QUERY, 4'd3,  4'd3);
        send_request(ACT_QUERY, 4'd3,  4'd9);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 550)
            begin
                sender_idle_pct    = 54;
                receiver_stall_pct = 27;
            end
            else if (i == 1100)
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            a = $urandom_range(15);
            b = $urandom_range(15);
            if (i < 1200)
            begin
                is_add = ($urandom_range(99) < 9);
                // keep edges pointing down so many pairs stay unreachable
                if (is_add && a < b)
                begin
                    tmp = a;
                    a   = b;
                    b   = tmp;
                end
            end
            else
            begin
                is_add = ($urandom_range(99) < 4);
            end
            send_request(is_add ? ACT_ADD : ACT_QUERY, 4'(a), 4'(b));
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        if (sb.failures == 0)
        begin
            $display("[graph_dfs_reachability] OK");
        end
        else
        begin
            $display("[graph_dfs_reachability] ERROR");
        end
        $finish;
    end

    initial
    begin
        #15ms;
        $display("[graph_dfs_reachability] ERROR");
        $finish;
    end

endmodule
